/* rtl/frp_pkg.sv */
`default_nettype none

package frp_pkg;

  // Binary point of the incoming mantissa sits after this bit.
  localparam int POINT_POSITION = 62;

  localparam int MANT_W   = 64;
  localparam int EXP_IN_W = 13;
  localparam int EXP_W    = 15;  // holds exponent_in plus the leading-one offset
  localparam int LZ_W     = 6;   // bit index into the mantissa
  localparam int SHIFT_W  = 7;   // denormalize shift, saturates at MANT_W
  localparam int FRAC_W   = 52;  // widest stored fraction (double)
  localparam int EXPF_W   = 11;  // widest exponent field (double)
  localparam int RES_W    = 64;

  typedef logic [1:0] prec_t;
  localparam prec_t PREC_HALF   = 2'd0;
  localparam prec_t PREC_SINGLE = 2'd1;
  localparam prec_t PREC_DOUBLE = 2'd2;

  typedef logic [2:0] rmode_t;
  localparam rmode_t RM_NEAREST   = 3'd0;
  localparam rmode_t RM_PLUS_INF  = 3'd1;
  localparam rmode_t RM_MINUS_INF = 3'd2;
  localparam rmode_t RM_ZERO      = 3'd3;
  localparam rmode_t RM_ODD       = 3'd4;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FTZ      = 2'd0;
  localparam cfg_idx_t CFG_FTZ_HALF = 2'd1;
  localparam cfg_idx_t CFG_AHP      = 2'd2;
  localparam cfg_idx_t CFG_UFE      = 2'd3;

  // Alternative half saturation magnitude
  localparam logic [14:0] AHP_SAT = 15'h7FFF;

  typedef struct packed {
    logic ftz;
    logic ftz_half;
    logic ahp;
    logic ufe;
  } cfg_t;

  // Transaction leaving the normalize/denormalize stages
  typedef struct packed {
    logic              valid;
    logic              sign;
    prec_t             prec;
    rmode_t            mode;
    logic              zero;
    logic              flush;
    logic              unf;
    logic              rnd;
    logic              stk;
    logic [FRAC_W-1:0] frac;
    logic [EXP_W-1:0]  biased;
  } mid_t;

  function automatic logic signed [EXP_W-1:0] min_exp(prec_t p);
    logic signed [EXP_W-1:0] r;
    unique case (p)
      PREC_HALF:   r = EXP_W'(-14);
      PREC_SINGLE: r = EXP_W'(-126);
      default:     r = EXP_W'(-1022);
    endcase
    return r;
  endfunction

  // All-ones biased exponent of the format
  function automatic logic [EXPF_W-1:0] exp_max(prec_t p);
    logic [EXPF_W-1:0] r;
    unique case (p)
      PREC_HALF:   r = EXPF_W'(31);
      PREC_SINGLE: r = EXPF_W'(255);
      default:     r = EXPF_W'(2047);
    endcase
    return r;
  endfunction

  function automatic logic [FRAC_W-1:0] frac_mask(prec_t p);
    logic [FRAC_W-1:0] r;
    unique case (p)
      PREC_HALF:   r = FRAC_W'(52'h3FF);
      PREC_SINGLE: r = FRAC_W'(52'h7FFFFF);
      default:     r = '1;
    endcase
    return r;
  endfunction

  function automatic logic [RES_W-1:0] pack(prec_t p, logic s, logic [EXPF_W-1:0] e,
                                            logic [FRAC_W-1:0] f);
    logic [RES_W-1:0] r;
    unique case (p)
      PREC_HALF:   r = {48'b0, s, e[4:0], f[9:0]};
      PREC_SINGLE: r = {32'b0, s, e[7:0], f[22:0]};
      default:     r = {s, e[10:0], f[51:0]};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/frp_norm.sv */
`default_nettype none

module frp_norm (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  input  frp_pkg::cfg_t                       cfg,
  input  wire  [1:0]                          in_precision,
  input  wire                                 in_sign_in,
  input  wire  signed [frp_pkg::EXP_IN_W-1:0] in_exponent_in,
  input  wire  [frp_pkg::MANT_W-1:0]          in_mantissa_in,
  input  wire  [2:0]                          in_rounding_mode,
  output frp_pkg::mid_t                       mid
);
  import frp_pkg::*;

  function automatic logic [LZ_W-1:0] lead_one(logic [MANT_W-1:0] m);
    logic [LZ_W-1:0] h;
    h = '0;
    for (int i = 0; i < MANT_W; i++) begin
      if (m[i]) h = LZ_W'(i);
    end
    return h;
  endfunction

  // ---- stage 1: leading-one search
  logic                       v1_r;
  logic                       sign1_r;
  prec_t                      prec1_r;
  rmode_t                     mode1_r;
  logic signed [EXP_IN_W-1:0] exp1_r;
  logic [MANT_W-1:0]          m1_r;
  logic [LZ_W-1:0]            h1_r;
  logic                       zero1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    sign1_r <= in_sign_in;
    prec1_r <= in_precision;
    mode1_r <= in_rounding_mode;
    exp1_r  <= in_exponent_in;
    m1_r    <= in_mantissa_in;
    h1_r    <= lead_one(in_mantissa_in);
    zero1_r <= (in_mantissa_in == '0);
  end

  // ---- stage 2: normalize, exponent and tininess
  logic signed [EXP_W-1:0] expo_nxt;
  logic signed [EXP_W-1:0] mine_nxt;
  logic signed [EXP_W-1:0] dist_nxt;
  logic signed [EXP_W-1:0] bias_nxt;
  logic                    tiny_nxt;
  logic [SHIFT_W-1:0]      dsh_nxt;

  always_comb begin
    expo_nxt = EXP_W'(exp1_r) + EXP_W'(h1_r) - EXP_W'(POINT_POSITION);
    mine_nxt = min_exp(prec1_r);
    tiny_nxt = expo_nxt < mine_nxt;
    dist_nxt = mine_nxt - expo_nxt;
    bias_nxt = expo_nxt - mine_nxt + EXP_W'(1);
    if (!tiny_nxt) begin
      dsh_nxt = '0;
    end else if (|dist_nxt[EXP_W-1:LZ_W]) begin
      dsh_nxt = SHIFT_W'(MANT_W);
    end else begin
      dsh_nxt = {1'b0, dist_nxt[LZ_W-1:0]};
    end
  end

  logic               v2_r;
  logic               sign2_r;
  prec_t              prec2_r;
  rmode_t             mode2_r;
  logic               zero2_r;
  logic               tiny2_r;
  logic               flush2_r;
  logic [MANT_W-1:0]  norm2_r;
  logic [SHIFT_W-1:0] dsh2_r;
  logic [EXP_W-1:0]   bias2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    sign2_r  <= sign1_r;
    prec2_r  <= prec1_r;
    mode2_r  <= mode1_r;
    zero2_r  <= zero1_r;
    tiny2_r  <= tiny_nxt;
    flush2_r <= tiny_nxt && ((prec1_r == PREC_HALF) ? cfg.ftz_half : cfg.ftz);
    norm2_r  <= m1_r << (LZ_W'(MANT_W - 1) - h1_r);
    dsh2_r   <= dsh_nxt;
    bias2_r  <= tiny_nxt ? '0 : bias_nxt;
  end

  // ---- stage 3: denormalize, round and sticky bits
  logic [MANT_W-1:0] shifted;
  logic [MANT_W-1:0] lost_mask;
  logic              lost;
  logic [FRAC_W-1:0] frac_nxt;
  logic              rnd_nxt;
  logic              stk_nxt;

  always_comb begin
    shifted   = norm2_r >> dsh2_r;
    lost_mask = ~({MANT_W{1'b1}} << dsh2_r);
    lost      = |(norm2_r & lost_mask);
    unique case (prec2_r)
      PREC_HALF: begin
        frac_nxt = FRAC_W'(shifted[62:53]);
        rnd_nxt  = shifted[52];
        stk_nxt  = (|shifted[51:0]) | lost;
      end
      PREC_SINGLE: begin
        frac_nxt = FRAC_W'(shifted[62:40]);
        rnd_nxt  = shifted[39];
        stk_nxt  = (|shifted[38:0]) | lost;
      end
      default: begin
        frac_nxt = shifted[62:11];
        rnd_nxt  = shifted[10];
        stk_nxt  = (|shifted[9:0]) | lost;
      end
    endcase
  end

  logic v3_r;
  mid_t mid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    mid_r.valid  <= 1'b0;
    mid_r.sign   <= sign2_r;
    mid_r.prec   <= prec2_r;
    mid_r.mode   <= mode2_r;
    mid_r.zero   <= zero2_r;
    mid_r.flush  <= flush2_r;
    mid_r.unf    <= tiny2_r && (rnd_nxt || stk_nxt || cfg.ufe);
    mid_r.rnd    <= rnd_nxt;
    mid_r.stk    <= stk_nxt;
    mid_r.frac   <= frac_nxt;
    mid_r.biased <= bias2_r;
  end

  always_comb begin
    mid       = mid_r;
    mid.valid = v3_r;
  end

endmodule

`default_nettype wire

/* rtl/fp_round_pack_unit.sv */
`default_nettype none

// Round-and-pack unit: takes an unpacked value (sign, signed exponent of
// mantissa bit 62, 64-bit mantissa, zero giving a signed zero) and returns it rounded and packed
// as binary16, binary32 or binary64 in the low bits of out_packed_result,
// together with invalid, overflow, underflow and inexact flags.
//
// Input channel: a transaction is taken at each rising edge with start high
// and busy low. busy is always low, so one transaction enters every cycle.
// Result channel: out_valid is high for exactly one cycle per transaction;
// the result of a transaction is registered through S1 to S5 below and is
// driven from the S5 output registers (one result per cycle sustained).
// Results leave in the order the transactions came in.
// The receiver cannot stall: results are never held and no handshake back.
//
// Pipeline: S1 leading-one search, S2 normalize shift and exponent/tiny
// check, S3 denormalize shift with round/sticky extraction, S4 rounding
// increment, S5 exponent carry, overflow handling and packing (output regs).
//
// Config: cfg_we writes cfg_wdata into register cfg_index (0 flush-to-zero,
// 1 half flush-to-zero, 2 alternative half, 3 underflow enable). Write only
// while no transaction is in flight. Synchronous reset (rst_n low) clears
// the config registers and all pipeline valid bits.

module fp_round_pack_unit (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  output logic                                busy,
  input  wire  [1:0]                          in_precision,
  input  wire                                 in_sign_in,
  input  wire  signed [frp_pkg::EXP_IN_W-1:0] in_exponent_in,
  input  wire  [frp_pkg::MANT_W-1:0]          in_mantissa_in,
  input  wire  [2:0]                          in_rounding_mode,
  output logic                                out_valid,
  output logic [frp_pkg::RES_W-1:0]           out_packed_result,
  output logic                                out_invalid_flag,
  output logic                                out_overflow_flag,
  output logic                                out_underflow_flag,
  output logic                                out_inexact_flag,
  input  wire                                 cfg_we,
  input  wire  [1:0]                          cfg_index,
  input  wire                                 cfg_wdata
);
  import frp_pkg::*;

  // Fully pipelined, never back-pressures
  assign busy = 1'b0;

  // ---- configuration registers
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FTZ:      cfg_r.ftz      <= cfg_wdata;
        CFG_FTZ_HALF: cfg_r.ftz_half <= cfg_wdata;
        CFG_AHP:      cfg_r.ahp      <= cfg_wdata;
        CFG_UFE:      cfg_r.ufe      <= cfg_wdata;
        default:      cfg_r          <= cfg_r;
      endcase
    end
  end

  // ---- stages 1..3
  mid_t mid;

  frp_norm u_norm (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (start && !busy),
    .cfg              (cfg_r),
    .in_precision     (in_precision),
    .in_sign_in       (in_sign_in),
    .in_exponent_in   (in_exponent_in),
    .in_mantissa_in   (in_mantissa_in),
    .in_rounding_mode (in_rounding_mode),
    .mid              (mid)
  );

  // ---- stage 4: rounding decision and fraction increment
  logic              err;
  logic              round_up;
  logic              to_inf;
  logic [FRAC_W-1:0] fmask;
  logic [FRAC_W-1:0] frac_nxt;
  logic              carry_nxt;

  always_comb begin
    err   = mid.rnd | mid.stk;
    fmask = frac_mask(mid.prec);
    unique case (mid.mode)
      RM_NEAREST: begin
        round_up = mid.rnd & (mid.stk | mid.frac[0]);
        to_inf   = 1'b1;
      end
      RM_PLUS_INF: begin
        round_up = err & ~mid.sign;
        to_inf   = ~mid.sign;
      end
      RM_MINUS_INF: begin
        round_up = err & mid.sign;
        to_inf   = mid.sign;
      end
      default: begin
        // toward zero, to odd, and unused codes truncate; to odd then sets the LSB when inexact
        round_up = 1'b0;
        to_inf   = 1'b0;
      end
    endcase
    // all-ones fraction rolls over into the exponent
    carry_nxt = round_up && (mid.frac == fmask);
    frac_nxt  = (mid.frac + FRAC_W'(round_up)) & fmask;
    if (mid.mode == RM_ODD && err) frac_nxt[0] = 1'b1;
  end

  logic              v4_r;
  logic              sign4_r;
  prec_t             prec4_r;
  logic              zero4_r;
  logic              flush4_r;
  logic              unf4_r;
  logic              err4_r;
  logic              to_inf4_r;
  logic [FRAC_W-1:0] frac4_r;
  logic              carry4_r;
  logic [EXP_W-1:0]  bias4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= mid.valid;
    end
  end

  always_ff @(posedge clk) begin
    sign4_r   <= mid.sign;
    prec4_r   <= mid.prec;
    zero4_r   <= mid.zero;
    flush4_r  <= mid.flush;
    unf4_r    <= mid.unf;
    err4_r    <= err;
    to_inf4_r <= to_inf;
    frac4_r   <= frac_nxt;
    carry4_r  <= carry_nxt;
    bias4_r   <= mid.biased;
  end

  // ---- stage 5: exponent carry, overflow and packing
  logic [EXP_W-1:0]  bias_f;
  logic [EXPF_W-1:0] emax;
  logic              ahp;
  logic [RES_W-1:0]  res_nxt;
  logic              inv_nxt;
  logic              ovf_nxt;
  logic              unf_nxt;
  logic              inx_nxt;

  always_comb begin
    bias_f  = bias4_r + EXP_W'(carry4_r);
    emax    = exp_max(prec4_r);
    ahp     = (prec4_r == PREC_HALF) && cfg_r.ahp;
    res_nxt = pack(prec4_r, sign4_r, bias_f[EXPF_W-1:0], frac4_r);
    inv_nxt = 1'b0;
    ovf_nxt = 1'b0;
    unf_nxt = unf4_r;
    inx_nxt = err4_r;
    priority if (zero4_r) begin
      res_nxt = pack(prec4_r, sign4_r, '0, '0);
      unf_nxt = 1'b0;
      inx_nxt = 1'b0;
    end else if (flush4_r) begin
      res_nxt = pack(prec4_r, sign4_r, '0, '0);
      unf_nxt = 1'b1;
      inx_nxt = 1'b0;
    end else if (ahp) begin
      // no infinities: saturate and signal invalid
      if (bias_f > EXP_W'(emax)) begin
        res_nxt = {48'b0, sign4_r, AHP_SAT};
        inv_nxt = 1'b1;
        inx_nxt = 1'b0;
      end
    end else if (bias_f >= EXP_W'(emax)) begin
      res_nxt = to_inf4_r ? pack(prec4_r, sign4_r, emax, '0)
                          : pack(prec4_r, sign4_r, emax - EXPF_W'(1), frac_mask(prec4_r));
      ovf_nxt = 1'b1;
      inx_nxt = 1'b1;
    end
  end

  logic             out_valid_r;
  logic [RES_W-1:0] res_r;
  logic             inv_r;
  logic             ovf_r;
  logic             unf_r;
  logic             inx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    inv_r <= inv_nxt;
    ovf_r <= ovf_nxt;
    unf_r <= unf_nxt;
    inx_r <= inx_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_packed_result  = res_r;
  assign out_invalid_flag   = inv_r;
  assign out_overflow_flag  = ovf_r;
  assign out_underflow_flag = unf_r;
  assign out_inexact_flag   = inx_r;

endmodule

`default_nettype wire
